/* design/nfci_pkg.sv */
// Package for the NOR flash command interface: item field codes, command and
// data byte constants, and the control and status bundles between blocks.
// No dependencies.
package nfci_pkg;

   // Default array size and the fixed erase sector size.
   localparam int NFCI_FLASH_BYTES  = 524288;
   localparam int NFCI_SECTOR_BYTES = 4096;
   localparam int NFCI_SECTOR_AW    = $clog2(NFCI_SECTOR_BYTES);

   // Item kinds carried in tuser.
   localparam logic [1:0] OP_READ    = 2'd0;
   localparam logic [1:0] OP_WRITE   = 2'd1;
   localparam logic [1:0] OP_PRELOAD = 2'd2;

   // Unlock addresses, with the bank bits dropped.
   localparam logic [14:0] ADDR_UNLOCK1 = 15'h5555;
   localparam logic [14:0] ADDR_UNLOCK2 = 15'h2AAA;

   // Command and data bytes.
   localparam logic [7:0] DATA_UNLOCK1      = 8'hAA;
   localparam logic [7:0] DATA_UNLOCK2      = 8'h55;
   localparam logic [7:0] CMD_PROGRAM       = 8'hA0;
   localparam logic [7:0] CMD_ERASE         = 8'h80;
   localparam logic [7:0] CMD_ID_ENTRY      = 8'h90;
   localparam logic [7:0] CMD_ID_EXIT       = 8'hF0;
   localparam logic [7:0] CMD_CHIP_ERASE    = 8'h10;
   localparam logic [7:0] CMD_SECTOR_ERASE  = 8'h30;
   localparam logic [7:0] ID_MANUFACTURER   = 8'hBF;
   localparam logic [7:0] ID_DEVICE         = 8'hB7;
   localparam logic [7:0] ERASED_BYTE       = 8'hFF;

   // Source of the read_data byte of a result.
   typedef enum logic [1:0] {
      RD_ZERO  = 2'd0,
      RD_ARRAY = 2'd1,
      RD_ID    = 2'd2
   } rd_sel_type;

   // Decoded view of the captured word, sent from datapath to controller.
   typedef struct packed {
      logic [1:0] op;
      logic       bank_hit;
      logic       cpu_hi;
      logic       cmd_5555;
      logic       cmd_2aaa;
      logic       d_aa;
      logic       d_55;
      logic       d_a0;
      logic       d_80;
      logic       d_90;
      logic       d_f0;
      logic       d_10;
      logic       d_30;
      logic       erase_last;
   } dp_status_type;

   // Datapath controls issued by the controller.
   typedef struct packed {
      logic       capture;
      logic       load_bank;
      logic       mem_rd;
      logic       prog_wr;
      logic       preload_wr;
      logic       erase_chip;
      logic       erase_sector;
      logic       erase_run;
      logic       out_load;
      rd_sel_type rd_sel;
      logic       id_mode;
   } dp_cmd_type;

endpackage

/* design/nor_flash_command_interface.sv */
// NOR flash command interface, top level, with one word in flight at a time.
// A word is captured on accept and executed. A byte program then writes back the stored byte,
// an erase sweeps one sector or the whole array, and the result is registered (the erase
// sweep writes one array byte per cycle). A new word is taken only once the result of the
// last one has been loaded, which waits while a pending result is not taken by the result side.
// Synchronous reset clears control state, bank register and ID mode; the array is not swept.
module nor_flash_command_interface
   import nfci_pkg::*;
#(
   parameter int FLASH_BYTES = NFCI_FLASH_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,    // flash_enabled
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,    // cpu_address, write_data, image_address
   input  logic [1:0]  req_tuser,    // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata     // read_data, prg_bank, chr_page, nametable_page,
                                     // red_led_off, green_led_off, id_mode_active
);

   dp_status_type status;
   dp_cmd_type    cmd;

   nfci_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   nfci_datapath #(
      .FLASH_BYTES (FLASH_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

/* design/nfci_datapath.sv */
// Datapath of the NOR flash command interface: captured word, bank register,
// address reduction, flash array memory, erase pointer and result register.
// Depends on nfci_pkg.
module nfci_datapath
   import nfci_pkg::*;
#(
   parameter int FLASH_BYTES = NFCI_FLASH_BYTES
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [47:0]   req_tdata,
   input  logic [1:0]    req_tuser,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic [23:0]   rsp_tdata
);

   localparam int AW = $clog2(FLASH_BYTES);

   // Reduce a 19-bit address modulo the array size; at most seven wraps.
   function automatic logic [AW-1:0] reduce_addr(input logic [18:0] v);
      logic [18:0] r;
      r = v;
      for (int k = 1; k < 8; k++) begin
         if ({4'b0, v} >= 23'(k * FLASH_BYTES)) begin
            r = v - 19'(k * FLASH_BYTES);
         end
      end
      return r[AW-1:0];
   endfunction

   logic [1:0]    op_ff;
   logic [15:0]   cpu_ff;
   logic [7:0]    data_ff;
   logic [AW-1:0] arr_addr_ff;
   logic [AW-1:0] img_addr_ff;
   logic [7:0]    bank_ff;
   logic [7:0]    bank_in;
   logic [7:0]    rdata_ff;
   logic [AW-1:0] ptr_ff;
   logic [AW-1:0] ptr_in;
   logic          chip_ff;
   logic          chip_in;
   logic [23:0]   out_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic [7:0]    rd_byte;
   logic [7:0]    mem [FLASH_BYTES];

   // Capture the word with its array and image addresses already reduced.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_tuser;
         cpu_ff      <= req_tdata[15:0];
         data_ff     <= req_tdata[23:16];
         arr_addr_ff <= reduce_addr({bank_ff[3:0], req_tdata[14:0]});
         img_addr_ff <= reduce_addr(req_tdata[42:24]);
      end
   end

   // Bank register.
   assign bank_in = cmd.load_bank ? data_ff : bank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= 8'hFF;
      end else begin
         bank_ff <= bank_in;
      end
   end

   // Erase sweep pointer: whole array from zero, or one sector from its base.
   always_comb begin
      ptr_in  = ptr_ff;
      chip_in = chip_ff;
      priority if (cmd.erase_chip) begin
         ptr_in  = '0;
         chip_in = 1'b1;
      end else if (cmd.erase_sector) begin
         ptr_in  = {arr_addr_ff[AW-1:NFCI_SECTOR_AW], {NFCI_SECTOR_AW{1'b0}}};
         chip_in = 1'b0;
      end else if (cmd.erase_run) begin
         ptr_in  = ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      chip_ff <= chip_in;
   end

   // Status for the controller.
   always_comb begin
      status.op         = op_ff;
      status.bank_hit   = (cpu_ff[15:12] == 4'h5) || (cpu_ff[15:12] == 4'h7);
      status.cpu_hi     = cpu_ff[15];
      status.cmd_5555   = (cpu_ff[14:0] == ADDR_UNLOCK1);
      status.cmd_2aaa   = (cpu_ff[14:0] == ADDR_UNLOCK2);
      status.d_aa       = (data_ff == DATA_UNLOCK1);
      status.d_55       = (data_ff == DATA_UNLOCK2);
      status.d_a0       = (data_ff == CMD_PROGRAM);
      status.d_80       = (data_ff == CMD_ERASE);
      status.d_90       = (data_ff == CMD_ID_ENTRY);
      status.d_f0       = (data_ff == CMD_ID_EXIT);
      status.d_10       = (data_ff == CMD_CHIP_ERASE);
      status.d_30       = (data_ff == CMD_SECTOR_ERASE);
      status.erase_last = (ptr_ff == AW'(FLASH_BYTES - 1)) ||
                          (!chip_ff && (&ptr_ff[NFCI_SECTOR_AW-1:0]));
   end

   // Write port: preload, program (AND into the stored byte) or erase.
   always_comb begin
      mem_we    = cmd.preload_wr || cmd.prog_wr || cmd.erase_run;
      mem_waddr = ptr_ff;
      mem_wdata = ERASED_BYTE;
      priority if (cmd.preload_wr) begin
         mem_waddr = img_addr_ff;
         mem_wdata = data_ff;
      end else if (cmd.prog_wr) begin
         mem_waddr = arr_addr_ff;
         mem_wdata = rdata_ff & data_ff;
      end
   end

   // Flash array with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rdata_ff <= mem[arr_addr_ff];
      end
   end

   // Read byte of the result.
   always_comb begin
      unique case (cmd.rd_sel)
         RD_ARRAY: rd_byte = rdata_ff;
         RD_ID: begin
            if (cpu_ff[8:0] == 9'd0) begin
               rd_byte = ID_MANUFACTURER;
            end else if (cpu_ff[8:0] == 9'd1) begin
               rd_byte = ID_DEVICE;
            end else begin
               rd_byte = ERASED_BYTE;
            end
         end
         default: rd_byte = 8'h00;
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff <= {7'b0, cmd.id_mode, bank_ff, rd_byte};
      end
   end

   assign rsp_tdata = out_ff;

endmodule

/* design/nfci_controller.sv */
// Controller of the NOR flash command interface: item sequencer, unlock and
// command state machine, ID mode, flash enable register and result valid.
// Depends on nfci_pkg.
module nfci_controller
   import nfci_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic          csr_wdata,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_PROG  = 5'b00100,
      S_ERASE = 5'b01000,
      S_RESP  = 5'b10000
   } seq_state_type;

   typedef enum logic [3:0] {
      CM_READY   = 4'b0001,
      CM_COMMAND = 4'b0010,
      CM_PROGRAM = 4'b0100,
      CM_ERASE   = 4'b1000
   } cmd_mode_type;

   seq_state_type state_ff, state_in;
   cmd_mode_type  cmode_ff, cmode_in;
   logic [1:0]    step_ff, step_in;
   logic          id_ff, id_in;
   logic          enabled_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;
   logic          flash_write;

   assign req_tready  = (state_ff == S_IDLE);
   assign rsp_tvalid  = rsp_valid_ff;
   assign accept      = req_tvalid && req_tready;
   assign flash_write = (status.op == OP_WRITE) && !status.bank_hit &&
                        status.cpu_hi && enabled_ff;

   // Flash enable register.
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
      end else if (csr_we) begin
         enabled_ff <= csr_wdata;
      end
   end

   // Sequencer and command state machine.
   always_comb begin
      state_in     = state_ff;
      cmode_in     = cmode_ff;
      step_in      = step_ff;
      id_in        = id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.rd_sel   = RD_ZERO;
      cmd.id_mode  = id_ff;

      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = accept;
            if (accept) begin
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            cmd.mem_rd     = 1'b1;
            cmd.preload_wr = (status.op == OP_PRELOAD);
            cmd.load_bank  = (status.op == OP_WRITE) && status.bank_hit;
            state_in       = S_RESP;
            if (flash_write) begin
               unique case (cmode_ff)
                  CM_READY: begin
                     if (status.cmd_5555 && status.d_aa) begin
                        cmode_in = CM_COMMAND;
                        step_in  = 2'd0;
                     end else if (status.d_f0) begin
                        id_in = 1'b0;
                     end
                  end
                  CM_COMMAND: begin
                     if (step_ff == 2'd0 && status.cmd_2aaa && status.d_55) begin
                        step_in = 2'd1;
                     end else if (step_ff == 2'd1 && status.cmd_5555) begin
                        step_in = 2'd0;
                        if (status.d_a0) begin
                           cmode_in = CM_PROGRAM;
                        end else if (status.d_80) begin
                           cmode_in = CM_ERASE;
                        end else begin
                           cmode_in = CM_READY;
                           if (status.d_90) begin
                              id_in = 1'b1;
                           end else if (status.d_f0) begin
                              id_in = 1'b0;
                           end
                        end
                     end else begin
                        cmode_in = CM_READY;
                     end
                  end
                  CM_PROGRAM: begin
                     cmode_in = CM_READY;
                     state_in = S_PROG;
                  end
                  default: begin
                     if (step_ff == 2'd0 && status.cmd_5555 && status.d_aa) begin
                        step_in = 2'd1;
                     end else if (step_ff == 2'd1 && status.cmd_2aaa && status.d_55) begin
                        step_in = 2'd2;
                     end else begin
                        cmode_in = CM_READY;
                        if (step_ff == 2'd2) begin
                           if (status.cmd_5555 && status.d_10) begin
                              cmd.erase_chip = 1'b1;
                              state_in       = S_ERASE;
                           end else if (status.d_30) begin
                              cmd.erase_sector = 1'b1;
                              state_in         = S_ERASE;
                           end
                        end
                     end
                  end
               endcase
            end
         end

         // The stored byte arrived last cycle; write back the AND.
         S_PROG: begin
            cmd.prog_wr = 1'b1;
            state_in    = S_RESP;
         end

         // One erased byte per cycle until the sweep reaches its end.
         S_ERASE: begin
            cmd.erase_run = 1'b1;
            if (status.erase_last) begin
               state_in = S_RESP;
            end
         end

         // Load the result once the output register is free.
         default: begin
            if (status.op == OP_READ && status.cpu_hi) begin
               cmd.rd_sel = id_ff ? RD_ID : RD_ARRAY;
            end
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmode_ff     <= CM_READY;
         step_ff      <= 2'd0;
         id_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmode_ff     <= cmode_in;
         step_ff      <= step_in;
         id_ff        <= id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An accepted word is always executed on the next cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted word not executed");

   // The program write-back follows the read issued during execution.
   a_prog_after_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROG) |-> ($past(state_ff) == S_EXEC))
      else $error("program write without preceding read");

   // An erase sweep only runs after the command machine returned to ready.
   a_erase_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ERASE) |-> (cmode_ff == CM_READY))
      else $error("erase sweep while a command is pending");

   // The unlock step counts to two at most.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff != 2'd3)
      else $error("unlock step out of range");

   // A pending result is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(rsp_valid_ff))
      else $error("pending result dropped");

endmodule
